/* rtl/wsm_pkg.sv */
package wsm_pkg;

    // fixed field and register widths
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = 64;
    localparam int NUM_WORDS      = 4;
    localparam int CHARS_PER_WORD = WORD_W / BYTE_W;
    localparam int MAX_CHARS      = NUM_WORDS * CHARS_PER_WORD;
    localparam int LEN_W          = 6;
    localparam int CFG_IDX_W      = 3;

    // default pattern capacity
    localparam int DEF_PATTERN_CHARS = MAX_CHARS;

    // special characters
    localparam logic [BYTE_W-1:0] STAR_CHAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] ANY_CHAR     = 8'h3F;
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [BYTE_W-1:0] LOWER_A      = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z      = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_0 = 3'd0,
        REG_WORD_1 = 3'd1,
        REG_WORD_2 = 3'd2,
        REG_WORD_3 = 3'd3,
        REG_LENGTH = 3'd4
    } t_cfg_reg;

    // lower-case ascii letters map to upper case, everything else is kept
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        begin
            r = c;
            if (c >= LOWER_A && c <= LOWER_Z) begin
                r = c - CASE_OFFSET;
            end
            return r;
        end
    endfunction

endpackage

/* rtl/wsm_text_if.sv */
interface wsm_text_if;
    logic                        valid;
    logic                        ready;
    logic [wsm_pkg::BYTE_W-1:0]  text_byte;
    logic                        last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

/* rtl/wsm_result_if.sv */
interface wsm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

/* rtl/wsm_pattern_regs.sv */
module wsm_pattern_regs #(
    parameter int PATTERN_CHARS = wsm_pkg::DEF_PATTERN_CHARS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wsm_pkg::WORD_W-1:0]    i_cfg_data,
    output logic [PATTERN_CHARS-1:0]      o_star_mask,
    output logic [PATTERN_CHARS-1:0]      o_any_mask,
    output logic [wsm_pkg::BYTE_W-1:0]    o_pat_fold [PATTERN_CHARS],
    output logic [wsm_pkg::LEN_W-1:0]     o_len
);
    import wsm_pkg::*;

    logic [BYTE_W-1:0] r_pat [PATTERN_CHARS];
    logic [LEN_W-1:0]  r_len;

    // pattern bytes, each written from its slot of its word
    for (genvar k = 0; k < PATTERN_CHARS; k++) begin : g_char
        localparam logic [CFG_IDX_W-1:0] WIDX =
            CFG_IDX_W'(int'(REG_WORD_0) + k / CHARS_PER_WORD);
        localparam int LSB = BYTE_W * (k % CHARS_PER_WORD);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pat[k] <= '0;
            end else if (i_cfg_we && i_cfg_index == WIDX) begin
                r_pat[k] <= i_cfg_data[LSB +: BYTE_W];
            end
        end

        // character classes for the matcher
        assign o_star_mask[k] = (r_pat[k] == STAR_CHAR);
        assign o_any_mask[k]  = (r_pat[k] == ANY_CHAR);
        assign o_pat_fold[k]  = fold_case(r_pat[k]);
    end

    // pattern length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_we && i_cfg_index == REG_LENGTH) begin
            r_len <= i_cfg_data[LEN_W-1:0];
        end
    end

    // lengths beyond capacity use the full pattern
    assign o_len = (r_len > LEN_W'(PATTERN_CHARS)) ? LEN_W'(PATTERN_CHARS) : r_len;

endmodule

/* rtl/wsm_match_core.sv */
module wsm_match_core #(
    parameter int PATTERN_CHARS = wsm_pkg::DEF_PATTERN_CHARS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wsm_text_if.sink                   i_text,
    wsm_result_if.source               o_result,
    input  logic [PATTERN_CHARS-1:0]   i_star_mask,
    input  logic [PATTERN_CHARS-1:0]   i_any_mask,
    input  logic [wsm_pkg::BYTE_W-1:0] i_pat_fold [PATTERN_CHARS],
    input  logic [wsm_pkg::LEN_W-1:0]  i_len
);
    import wsm_pkg::*;

    // input stage
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;
    // automaton state
    logic [PATTERN_CHARS-1:0] r_active;
    logic                     r_seen;
    // result stage
    logic r_out_valid;
    logic r_matched;

    logic advance;
    logic in_take;

    logic [PATTERN_CHARS-1:0] len_mask;
    logic [PATTERN_CHARS-1:0] last_pos;
    logic [PATTERN_CHARS-1:0] lit_hit;
    logic [PATTERN_CHARS-1:0] act;
    logic [PATTERN_CHARS-1:0] star_go;
    logic [PATTERN_CHARS:0]   star_sum;
    logic [PATTERN_CHARS:0]   star_carry;
    logic [PATTERN_CHARS-1:0] act_open;
    logic [PATTERN_CHARS-1:0] n_active;
    logic                     hit;
    logic [BYTE_W-1:0]        text_fold;

    // handshake: a byte that ends no text never waits on the result side
    assign advance  = r_in_valid && (!r_last || !r_out_valid || o_result.ready);
    assign in_take  = i_text.valid && i_text.ready;
    assign i_text.ready = !r_in_valid || advance;

    assign text_fold = fold_case(r_byte);

    // per-position length window, final position and literal compare
    for (genvar i = 0; i < PATTERN_CHARS; i++) begin : g_pos
        assign len_mask[i] = (LEN_W'(i) < i_len);
        assign last_pos[i] = (i_len == LEN_W'(i + 1));
        assign lit_hit[i]  = !i_star_mask[i] &&
                             (i_any_mask[i] || (i_pat_fold[i] == text_fold));
    end

    // star closure: an active star also opens the following position,
    // carried along runs of stars by one add over the star mask
    assign act        = ({{(PATTERN_CHARS-1){1'b0}}, 1'b1} | r_active) & len_mask;
    assign star_go    = act & i_star_mask;
    assign star_sum   = {1'b0, i_star_mask} + {1'b0, star_go};
    assign star_carry = star_sum ^ {1'b0, i_star_mask} ^ {1'b0, star_go};
    assign act_open   = (act | star_carry[PATTERN_CHARS-1:0]) & len_mask;

    // step all positions on the current byte
    always_comb begin
        n_active = '0;
        hit      = 1'b0;
        if (i_len == '0) begin
            hit = 1'b1;
        end else if (r_byte != NEWLINE_CHAR) begin
            n_active = ((act_open & i_star_mask) | ((act_open & lit_hit) << 1)) & len_mask;
            hit      = |(act_open & (i_star_mask | lit_hit) & last_pos);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_text.text_byte;
            r_last <= i_text.last_byte;
        end
    end

    // automaton state, cleared at the end of each text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_seen   <= 1'b0;
        end else if (advance) begin
            if (r_last) begin
                r_active <= '0;
                r_seen   <= 1'b0;
            end else begin
                r_active <= n_active;
                r_seen   <= r_seen | hit;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_matched <= r_seen | hit;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.matched = r_matched;

    // a new result appears only after a final byte went through
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_last))
        else $error("result without a final byte");

    // state is back to reset after each text
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> (r_active == '0) && !r_seen)
        else $error("state not cleared after text end");

    // an empty pattern matches every text
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last && (i_len == '0) |=> r_out_valid && r_matched)
        else $error("empty pattern did not match");

    // the input stage stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |-> r_last && r_out_valid && !o_result.ready)
        else $error("input stage stalled without cause");

endmodule

/* rtl/wildcard_substring_match.sv */
// Wildcard substring matcher. Text arrives one byte per request on i_text,
// with last_byte marking the final byte; for that byte alone one result
// request leaves on o_result, matched = 1 if the configured pattern matched
// anywhere in the text within a single line. Letters compare without case,
// '?' takes one character, '*' zero or more (one or more if trailing);
// nothing matches newline, and an empty pattern matches any text.
// The user must load the pattern through the write port (words 0-3, then
// length) while no text is in flight; the block itself does not enforce it.
// A new byte is accepted every cycle; a text's result is registered once its
// final byte leaves the input register. The rate is set by the combinational
// update of all pattern positions (per-position compare plus one carry-chain
// add for star runs) between the input and result registers; only a final
// byte waits, and only while a previous result is not taken.
module wildcard_substring_match #(
    parameter int PATTERN_CHARS = wsm_pkg::DEF_PATTERN_CHARS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wsm_text_if.sink                      i_text,
    wsm_result_if.source                  o_result,
    input  logic                          i_cfg_we,
    input  logic [wsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wsm_pkg::WORD_W-1:0]    i_cfg_data
);
    import wsm_pkg::*;

    logic [PATTERN_CHARS-1:0] star_mask;
    logic [PATTERN_CHARS-1:0] any_mask;
    logic [BYTE_W-1:0]        pat_fold [PATTERN_CHARS];
    logic [LEN_W-1:0]         pat_len;

    // pattern registers and character classes
    wsm_pattern_regs #(
        .PATTERN_CHARS (PATTERN_CHARS)
    ) u_pattern_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_star_mask (star_mask),
        .o_any_mask  (any_mask),
        .o_pat_fold  (pat_fold),
        .o_len       (pat_len)
    );

    // bit-parallel matcher
    wsm_match_core #(
        .PATTERN_CHARS (PATTERN_CHARS)
    ) u_match_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (i_text),
        .o_result    (o_result),
        .i_star_mask (star_mask),
        .i_any_mask  (any_mask),
        .i_pat_fold  (pat_fold),
        .i_len       (pat_len)
    );

endmodule

/* tb/wildcard_substring_match_tb.sv */
`timescale 1ns / 1ps

module wildcard_substring_match_tb;
    import wsm_pkg::*;

    localparam int PATTERN_CHARS  = DEF_PATTERN_CHARS;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int RESULT_LATENCY = 2;
    localparam int RANDOM_ITEMS   = 700;
    localparam int LONG_HOLD      = 300;
    localparam int LIMIT_CYCLES   = 400000;

    typedef enum logic {ROW_WRITE, ROW_BYTE} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_cfg_reg          reg_index;
        logic [WORD_W-1:0] reg_data;
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
        bit                fixed;
        bit                fixed_matched;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    t_cfg_reg          cfg_index;
    logic [WORD_W-1:0] cfg_data;

    wsm_text_if   text_ch();
    wsm_result_if result_ch();

    wildcard_substring_match #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (text_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // matcher copy: pattern registers and automaton state
    logic [WORD_W-1:0] pat_words [0:NUM_WORDS-1];
    logic [LEN_W-1:0]  pat_len;
    logic [32:0]       open_pos;
    bit                text_hit;

    // expected match flags, oldest first
    bit                pending_matches [$];
    t_row              script [$];
    logic [BYTE_W-1:0] text_q [$];

    int errors          = 0;
    int bytes_sent      = 0;
    int texts_sent      = 0;
    int settings_used   = 0;
    int results_seen    = 0;
    int results_matched = 0;
    int hold_requests   = 0;
    int burst_left      = 0;
    int gap_max         = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("wildcard_substring_match test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns, result %0d: %s", $realtime, results_seen, what);
        errors++;
    endtask

    function automatic int clamped_len();
        return (pat_len > PATTERN_CHARS) ? PATTERN_CHARS : int'(pat_len);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_at(input int k);
        return pat_words[k / CHARS_PER_WORD][BYTE_W * (k % CHARS_PER_WORD) +: BYTE_W];
    endfunction

    function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
        if (c >= "a" && c <= "z") begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // advance all pattern positions by one text byte; 1 when a result is due
    function automatic bit advance_matcher(input logic [BYTE_W-1:0] c, input logic last,
                                           output bit matched);
        int                n;
        int                i;
        logic [32:0]       lmask;
        logic [32:0]       act;
        logic [32:0]       nxt;
        logic [BYTE_W-1:0] p;
        bit                hit;
        n = clamped_len();
        hit = 1'b0;
        matched = 1'b0;
        if (n == 0) begin
            hit = 1'b1;
            open_pos = '0;
        end else begin
            lmask = (33'd1 << n) - 33'd1;
            act = (open_pos | 33'd1) & lmask;
            nxt = '0;
            // a star also opens the next item at the same text position
            for (i = 0; i + 1 < n; i++) begin
                if (act[i] && pattern_at(i) == STAR_CHAR) begin
                    act[i + 1] = 1'b1;
                end
            end
            if (c != NEWLINE_CHAR) begin
                for (i = 0; i < n; i++) begin
                    if (act[i]) begin
                        p = pattern_at(i);
                        if (p == STAR_CHAR) begin
                            nxt[i] = 1'b1;
                            if (i + 1 == n) hit = 1'b1;
                        end else if (p == ANY_CHAR || upcase(p) == upcase(c)) begin
                            if (i + 1 == n) hit = 1'b1;
                            else nxt[i + 1] = 1'b1;
                        end
                    end
                end
            end
            open_pos = nxt & lmask;
        end
        if (hit) text_hit = 1'b1;
        if (last) begin
            matched = text_hit;
            open_pos = '0;
            text_hit = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one register write, write enable left high for back-to-back writes
    task automatic write_reg(input t_cfg_reg idx, input logic [WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        if (idx == REG_LENGTH) pat_len = data[LEN_W-1:0];
        else pat_words[int'(idx)] = data;
    endtask

    // one text request, with burst gaps in front; prediction at acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                             input bit fixed, input bit fixed_matched);
        int gap;
        bit m;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.last_byte <= last;
        do @(posedge i_clk); while (text_ch.ready !== 1'b1);
        bytes_sent++;
        if (advance_matcher(b, last, m)) begin
            pending_matches.push_back(fixed ? fixed_matched : m);
            texts_sent++;
        end
    endtask

    // sender pauses until every expected result is in and the block is quiet
    task automatic wait_idle();
        text_ch.valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    // directed table builders
    task automatic row_write(input t_cfg_reg idx, input logic [WORD_W-1:0] data);
        t_row r;
        r = '{ROW_WRITE, idx, data, 8'h00, 1'b0, 1'b0, 1'b0};
        script.push_back(r);
    endtask

    task automatic row_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input bit fixed, input bit fixed_matched);
        t_row r;
        r = '{ROW_BYTE, REG_WORD_0, '0, b, last, fixed, fixed_matched};
        script.push_back(r);
    endtask

    task automatic row_text(input string s, input bit fixed, input bit fixed_matched);
        int k;
        for (k = 0; k < s.len(); k++) begin
            row_byte(s[k], k == s.len() - 1, fixed, fixed_matched);
        end
    endtask

    // random text content
    function automatic logic [BYTE_W-1:0] text_char();
        string letters;
        int    r;
        letters = "abcABC";
        r = $urandom_range(0, 99);
        if (r < 70) return letters[$urandom_range(0, 5)];
        if (r < 80) return NEWLINE_CHAR;
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] line_char();
        logic [BYTE_W-1:0] c;
        do c = text_char(); while (c == NEWLINE_CHAR);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_char();
        string letters;
        int    r;
        letters = "abcAB";
        r = $urandom_range(0, 99);
        if (r < 45) return letters[$urandom_range(0, 4)];
        if (r < 60) return ANY_CHAR;
        if (r < 75) return STAR_CHAR;
        if (r < 78) return NEWLINE_CHAR;
        if (r < 81) return 8'h00;
        if (r < 88) return BYTE_W'($urandom_range(128, 255));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // noise, or noise around an instance built from the pattern
    task automatic build_text(input bit short_text);
        int                k;
        logic [BYTE_W-1:0] p;
        text_q.delete();
        if (short_text) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(text_char());
        end else if ($urandom_range(0, 9) < 4) begin
            repeat ($urandom_range(1, 12)) text_q.push_back(text_char());
        end else begin
            repeat ($urandom_range(0, 4)) text_q.push_back(text_char());
            for (k = 0; k < clamped_len(); k++) begin
                p = pattern_at(k);
                if (p == STAR_CHAR) begin
                    repeat ($urandom_range(0, 3)) text_q.push_back(line_char());
                end else if (p == ANY_CHAR || p == 8'h00) begin
                    text_q.push_back(line_char());
                end else if (upcase(p) >= "A" && upcase(p) <= "Z") begin
                    text_q.push_back($urandom_range(0, 1) ? (p ^ 8'h20) : p);
                end else begin
                    text_q.push_back(p);
                end
            end
            repeat ($urandom_range(0, 4)) text_q.push_back(text_char());
        end
        if (text_q.size() == 0) text_q.push_back(text_char());
    endtask

    // new pattern, every register written, starting at a random one
    task automatic load_random_pattern();
        logic [WORD_W-1:0] words [0:NUM_WORDS-1];
        logic [WORD_W-1:0] len_data;
        int                len;
        int                r;
        int                k;
        int                start;
        int                idx;
        r = $urandom_range(0, 9);
        case (r)
            0: len = 0;
            1: len = 1;
            2: len = PATTERN_CHARS;
            3: len = $urandom_range(PATTERN_CHARS + 1, 63);
            default: len = $urandom_range(2, 8);
        endcase
        for (k = 0; k < MAX_CHARS; k++) begin
            words[k / CHARS_PER_WORD][BYTE_W * (k % CHARS_PER_WORD) +: BYTE_W] = pattern_char();
        end
        len_data = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
        len_data[LEN_W-1:0] = LEN_W'(len);
        start = $urandom_range(0, 4);
        for (k = 0; k < 5; k++) begin
            idx = (start + k) % 5;
            write_reg(t_cfg_reg'(idx), (idx == int'(REG_LENGTH)) ? len_data : words[idx]);
        end
        cfg_we <= 1'b0;
    endtask

    // receiver ready pattern with long holds on request
    initial begin
        int mode;
        int span;
        int held;
        int served;
        int tick;
        mode = 0;
        span = 0;
        held = 0;
        served = 0;
        tick = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
            end
            span--;
            if (served != hold_requests) begin
                served = hold_requests;
                held = LONG_HOLD;
            end
            if (held > 0) begin
                held--;
                result_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: result_ch.ready <= (tick % 4 != 0);
                endcase
            end
        end
    end

    // result check against the oldest expected match flag
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            results_seen++;
            if (result_ch.matched === 1'b1) results_matched++;
            if (pending_matches.size() == 0) begin
                report_mismatch("result with no text finished");
            end else begin
                want = pending_matches.pop_front();
                if (result_ch.matched !== want) begin
                    report_mismatch($sformatf("matched got %b expected %b",
                                              result_ch.matched, want));
                end
            end
        end
    end

    // stimulus
    initial begin
        int  k;
        int  phase;
        int  random_bytes;
        bit  writing;
        bit  short_text;
        i_rst_n           <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= 8'h20;
        text_ch.last_byte <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_WORD_0;
        cfg_data          <= '0;
        for (k = 0; k < NUM_WORDS; k++) pat_words[k] = '0;
        pat_len = '0;
        open_pos = '0;
        text_hit = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern after reset matches any text, a lone newline too
        row_text("x", 1, 1);
        row_text("\n", 1, 1);
        // literal, any, literal with case folding; any never takes a newline
        row_write(REG_WORD_0, {40'd0, "c", ANY_CHAR, "a"});
        row_write(REG_LENGTH, 64'd3);
        row_text("xAbC", 0, 0);
        row_text("a\nc", 0, 0);
        // any at the end of the pattern needs a real character
        row_write(REG_WORD_0, {48'd0, ANY_CHAR, "a"});
        row_write(REG_LENGTH, 64'd2);
        row_text("a", 1, 0);
        // trailing star needs one more character
        row_write(REG_WORD_0, {40'd0, STAR_CHAR, "b", "a"});
        row_write(REG_LENGTH, 64'd3);
        row_text("ab", 0, 0);
        row_text("abz", 0, 0);
        // all stars in every word, oversized length clamps to full capacity
        row_write(REG_WORD_0, {8{STAR_CHAR}});
        row_write(REG_WORD_1, {8{STAR_CHAR}});
        row_write(REG_WORD_2, {8{STAR_CHAR}});
        row_write(REG_WORD_3, {8{STAR_CHAR}});
        row_write(REG_LENGTH, 64'd63);
        row_text("q", 1, 1);
        row_text("\n", 1, 0);
        // zero pattern byte is a literal that only a zero text byte equals
        row_write(REG_WORD_0, 64'd0);
        row_write(REG_LENGTH, 64'd1);
        row_text("a", 1, 0);
        // high bytes compare exactly
        row_write(REG_WORD_0, 64'hE1);
        row_byte(8'hC1, 1'b1, 1'b1, 1'b0);
        row_byte(8'hE1, 1'b1, 1'b1, 1'b1);

        // walk the directed table
        gap_max = 3;
        writing = 1'b0;
        settings_used = 1;
        foreach (script[k]) begin
            if (script[k].kind == ROW_WRITE) begin
                if (!writing) begin
                    wait_idle();
                    writing = 1'b1;
                    settings_used++;
                end
                write_reg(script[k].reg_index, script[k].reg_data);
            end else begin
                if (writing) begin
                    cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                send_byte(script[k].text_byte, script[k].last_byte,
                          script[k].fixed, script[k].fixed_matched);
            end
        end

        // random phases: new pattern, then a run of texts
        phase = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_ITEMS) begin
            wait_idle();
            load_random_pattern();
            settings_used++;
            short_text = (phase == 1 || phase == 4);
            if (short_text) hold_requests++;
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat ($urandom_range(4, 10)) begin
                build_text(short_text);
                for (k = 0; k < text_q.size(); k++) begin
                    send_byte(text_q[k], k == text_q.size() - 1, 1'b0, 1'b0);
                    random_bytes++;
                end
            end
            phase++;
        end

        // drain
        wait_idle();
        if (pending_matches.size() != 0) report_mismatch("texts left without a result");
        $display("covered %0d text bytes in %0d texts over %0d pattern settings",
                 bytes_sent, texts_sent, settings_used);
        $display("%0d results checked, %0d reported a match, %0d mismatches",
                 results_seen, results_matched, errors);
        if (errors == 0) begin
            $display("wildcard_substring_match test passed");
        end else begin
            $display("wildcard_substring_match test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/wsm_pkg.sv
rtl/wsm_text_if.sv
rtl/wsm_result_if.sv
rtl/wsm_pattern_regs.sv
rtl/wsm_match_core.sv
rtl/wildcard_substring_match.sv
tb/wildcard_substring_match_tb.sv
